// ----- design/amrtd_pkg.sv -----
`default_nettype none

package amrtd_pkg;

	// toc list capacity and derived widths
	localparam int MAX_TOCS = 16;
	localparam int TOC_AW   = (MAX_TOCS > 1) ? $clog2(MAX_TOCS) : 1;
	localparam int TOC_CW   = $clog2(MAX_TOCS + 1);
	localparam int LEN_W    = 5;
	localparam int KIND_W   = 4;

	// packet phase codes
	typedef logic [1:0] phase_t;
	localparam phase_t PH_CMR   = 2'd0;
	localparam phase_t PH_TOC   = 2'd1;
	localparam phase_t PH_DATA  = 2'd2;
	localparam phase_t PH_TRAIL = 2'd3;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_DATA  = 2'd0;
	localparam status_t ST_BADTOC = 2'd1;
	localparam status_t ST_TRUNC = 2'd2;
	localparam status_t ST_SHORT = 2'd3;

	// one result word, without the run marker
	typedef struct packed {
		logic [7:0]        out_byte;
		logic              frame_begin;
		logic              frame_end;
		logic [KIND_W-1:0] frame_kind;
		status_t           status;
	} res_t;

	// sequencer to output stage
	typedef struct packed {
		logic push;
		logic flush;
		res_t res;
	} emit_req_t;

	// toc memory write and read requests
	typedef struct packed {
		logic              we;
		logic [TOC_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic              re;
		logic [TOC_AW-1:0] addr;
	} mem_rd_t;

	// frame size in bytes for each frame type
	function automatic logic [LEN_W-1:0] frame_len(input logic [KIND_W-1:0] kind);
		logic [LEN_W-1:0] len;
		case (kind)
			4'd0: len = LEN_W'(12);
			4'd1: len = LEN_W'(13);
			4'd2: len = LEN_W'(15);
			4'd3: len = LEN_W'(17);
			4'd4: len = LEN_W'(19);
			4'd5: len = LEN_W'(20);
			4'd6: len = LEN_W'(26);
			4'd7: len = LEN_W'(31);
			4'd8: len = LEN_W'(5);
			default: len = '0;
		endcase
		return len;
	endfunction

	// frame type field of a toc byte
	function automatic logic [KIND_W-1:0] toc_kind(input logic [7:0] toc);
		return toc[6:3];
	endfunction

endpackage

`default_nettype wire

// ----- design/amrtd_in_if.sv -----
`default_nettype none

interface amrtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       packet_end;

	modport source (output valid, output payload_byte, output packet_end, input ready);
	modport sink (input valid, input payload_byte, input packet_end, output ready);
endinterface

`default_nettype wire

// ----- design/amrtd_out_if.sv -----
`default_nettype none

interface amrtd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_begin;
	logic       frame_end;
	logic [3:0] frame_kind;
	logic [1:0] status;
	logic       run_end;

	modport source (output valid, output out_byte, output frame_begin, output frame_end,
		output frame_kind, output status, output run_end, input ready);
	modport sink (input valid, input out_byte, input frame_begin, input frame_end,
		input frame_kind, input status, input run_end, output ready);
endinterface

`default_nettype wire

// ----- design/amrtd_toc_mem.sv -----
`default_nettype none

module amrtd_toc_mem
	import amrtd_pkg::*;
(
	input  wire logic    clk,
	input  wire mem_wr_t wr,
	input  wire mem_rd_t rd,
	output logic [7:0]   rd_data
);

	logic [7:0] mem [MAX_TOCS];

	// single write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd.re) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/amrtd_out_stage.sv -----
`default_nettype none

module amrtd_out_stage
	import amrtd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire emit_req_t req,
	output logic           room,
	amrtd_out_if.source    dout
);

	logic out_v_q;
	res_t out_q;
	logic run_end_q;
	logic hold_v_q;
	res_t hold_q;
	logic out_free;
	logic load;

	// the held word waits until the next one shows whether it ends the run
	assign out_free = !out_v_q || dout.ready;
	assign room     = !hold_v_q || out_free;
	assign load     = (req.push || req.flush) && room && hold_v_q;

	// hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (room) begin
			if (req.push) begin
				hold_v_q <= 1'b1;
			end else if (req.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && room) begin
			hold_q <= req.res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (dout.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q     <= hold_q;
			run_end_q <= req.flush;
		end
	end

	assign dout.valid       = out_v_q;
	assign dout.out_byte    = out_q.out_byte;
	assign dout.frame_begin = out_q.frame_begin;
	assign dout.frame_end   = out_q.frame_end;
	assign dout.frame_kind  = out_q.frame_kind;
	assign dout.status      = out_q.status;
	assign dout.run_end     = run_end_q;

endmodule

`default_nettype wire

// ----- design/amrtd_ctrl.sv -----
`default_nettype none

module amrtd_ctrl
	import amrtd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        acc,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             idle,
	output emit_req_t        req,
	input  wire logic        room,
	output mem_wr_t          wr,
	output mem_rd_t          rd,
	input  wire logic [7:0]  rd_data
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PROC   = 7'b0000010,
		S_BODY   = 7'b0000100,
		S_ADV_RD = 7'b0001000,
		S_ADV_EV = 7'b0010000,
		S_TRUNC  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            st_q;
	phase_t            phase_q;
	logic [TOC_CW-1:0] toc_total_q;
	logic [TOC_CW-1:0] cursor_q;
	logic [LEN_W-1:0]  rem_q;
	logic [7:0]        cur_toc_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic [KIND_W-1:0] k_cur;
	logic [LEN_W-1:0]  len_cur;
	logic [KIND_W-1:0] rd_kind;
	logic [LEN_W-1:0]  rd_len;
	logic              bad_list;
	logic              more;
	logic              stall;

	assign k_cur    = toc_kind(cur_toc_q);
	assign len_cur  = frame_len(k_cur);
	assign rd_kind  = toc_kind(rd_data);
	assign rd_len   = frame_len(rd_kind);
	assign bad_list = (toc_total_q >= TOC_CW'(MAX_TOCS)) || (byte_q[7] && last_q);
	assign more     = cursor_q < toc_total_q;
	assign idle     = st_q == S_IDLE;

	// result words produced by each step
	always_comb begin
		req = '0;
		case (st_q)
			S_PROC: begin
				case (phase_q)
					PH_CMR: begin
						if (last_q) begin
							req.push       = 1'b1;
							req.res.status = ST_SHORT;
						end
					end
					PH_TOC: begin
						if (bad_list) begin
							req.push       = 1'b1;
							req.res.status = ST_BADTOC;
						end
					end
					PH_DATA: begin
						if (rem_q == len_cur) begin
							req.push            = 1'b1;
							req.res.out_byte    = cur_toc_q;
							req.res.frame_begin = 1'b1;
							req.res.frame_kind  = k_cur;
							req.res.status      = ST_DATA;
						end
					end
					default: ;
				endcase
			end
			S_BODY: begin
				req.push           = 1'b1;
				req.res.out_byte   = byte_q;
				req.res.frame_end  = rem_q <= LEN_W'(1);
				req.res.frame_kind = k_cur;
				req.res.status     = ST_DATA;
			end
			S_ADV_EV: begin
				if (rd_len == '0) begin
					req.push            = 1'b1;
					req.res.out_byte    = rd_data;
					req.res.frame_begin = 1'b1;
					req.res.frame_end   = 1'b1;
					req.res.frame_kind  = rd_kind;
					req.res.status      = ST_DATA;
				end
			end
			S_TRUNC: begin
				req.push           = 1'b1;
				req.res.frame_kind = k_cur;
				req.res.status     = ST_TRUNC;
			end
			S_DONE: begin
				req.flush = 1'b1;
			end
			default: ;
		endcase
	end

	assign stall = (req.push || req.flush) && !room;

	// toc memory accesses
	always_comb begin
		wr.we   = (st_q == S_PROC) && (phase_q == PH_TOC) && !bad_list;
		wr.addr = toc_total_q[TOC_AW-1:0];
		wr.data = byte_q;
		rd.re   = (st_q == S_ADV_RD) && more;
		rd.addr = cursor_q[TOC_AW-1:0];
	end

	// sequencer and packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			phase_q     <= PH_CMR;
			toc_total_q <= '0;
			cursor_q    <= '0;
			rem_q       <= '0;
		end else if (!stall) begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						st_q <= S_PROC;
					end
				end
				S_PROC: begin
					case (phase_q)
						PH_CMR: begin
							if (!last_q) begin
								phase_q     <= PH_TOC;
								toc_total_q <= '0;
								cursor_q    <= '0;
								rem_q       <= '0;
							end
							st_q <= S_DONE;
						end
						PH_TOC: begin
							if (bad_list) begin
								phase_q <= PH_TRAIL;
								st_q    <= S_DONE;
							end else begin
								toc_total_q <= toc_total_q + TOC_CW'(1);
								if (!byte_q[7]) begin
									cursor_q <= '0;
									st_q     <= S_ADV_RD;
								end else begin
									st_q <= S_DONE;
								end
							end
						end
						PH_DATA: begin
							st_q <= S_BODY;
						end
						default: begin
							st_q <= S_DONE;
						end
					endcase
				end
				S_BODY: begin
					if (rem_q <= LEN_W'(1)) begin
						cursor_q <= cursor_q + TOC_CW'(1);
						st_q     <= S_ADV_RD;
					end else begin
						rem_q <= rem_q - LEN_W'(1);
						st_q  <= last_q ? S_TRUNC : S_DONE;
					end
				end
				S_ADV_RD: begin
					if (more) begin
						st_q <= S_ADV_EV;
					end else begin
						rem_q   <= '0;
						phase_q <= PH_TRAIL;
						st_q    <= S_DONE;
					end
				end
				S_ADV_EV: begin
					if (rd_len != '0) begin
						rem_q   <= rd_len;
						phase_q <= PH_DATA;
						st_q    <= last_q ? S_TRUNC : S_DONE;
					end else begin
						cursor_q <= cursor_q + TOC_CW'(1);
						st_q     <= S_ADV_RD;
					end
				end
				S_TRUNC: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (last_q) begin
						phase_q     <= PH_CMR;
						toc_total_q <= '0;
						cursor_q    <= '0;
						rem_q       <= '0;
					end
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// latched input word and current toc
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && acc) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (st_q == S_ADV_EV && rd_len != '0) begin
			cur_toc_q <= rd_data;
		end
	end

	// checks
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= toc_total_q)
		else $error("toc cursor beyond toc count");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		toc_total_q <= TOC_CW'(MAX_TOCS))
		else $error("toc count beyond capacity");

	a_data_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("frame data phase with no bytes remaining");

	// an evaluation either follows its read or waits there for output room
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_ADV_EV |-> ($past(st_q) == S_ADV_RD || $past(st_q) == S_ADV_EV))
		else $error("toc evaluated without a read");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> !req.push && !req.flush)
		else $error("result produced while idle");

endmodule

`default_nettype wire

// ----- design/amr_payload_toc_deframer_top.sv -----
`default_nettype none

// AMR-NB octet-aligned payload deframer.
// din carries one packet word per handshake: payload_byte plus packet_end on
// the final word. The CMR word is dropped, TOC words are kept in a small
// memory, and frame data comes out on dout as the frame's TOC word
// (frame_begin) followed by its data words (frame_end on the last one).
// status flags short packets, bad TOC lists and truncated frames; run_end
// marks the last result word caused by one input word.
// An input word is taken only when the sequencer is idle. A word passes
// through PROC and DONE (CMR, TOC, trailing word or bad list), a data word
// also through BODY, and one that reports a truncated frame also through
// TRUNC. A TOC list end or frame end adds, per TOC scanned, an ADV_RD
// memory read and an ADV_EV evaluation, plus an ADV_RD when it runs out.
// A result reaches dout once the sequencer makes the next one or finishes
// the word, so the last result is on dout when the next word can be taken.
// When dout stalls, one result sits in the output register and one in a
// hold register; the sequencer then waits, and din stays not ready.
// Reset (arst_n low) empties both registers and returns the block to
// waiting for a CMR word; the TOC memory needs no clearing pass.
module amr_payload_toc_deframer_top
	import amrtd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	amrtd_in_if.sink    din,
	amrtd_out_if.source dout
);

	logic      idle;
	logic      acc;
	logic      room;
	emit_req_t req;
	mem_wr_t   wr;
	mem_rd_t   rd;
	logic [7:0] rd_data;

	// input handshake
	assign din.ready = idle;
	assign acc       = din.valid && idle;

	amrtd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (din.payload_byte),
		.in_last (din.packet_end),
		.idle    (idle),
		.req     (req),
		.room    (room),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	amrtd_toc_mem u_toc_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	amrtd_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.room   (room),
		.dout   (dout)
	);

endmodule

`default_nettype wire
